// File: sv/waveform_box_smoother_core_defines.svh
// assertion macros for the waveform box smoother core
// no dependencies; the asserting modules must provide clock and reset
`ifndef WAVEFORM_BOX_SMOOTHER_CORE_DEFINES_SVH
`define WAVEFORM_BOX_SMOOTHER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define WSM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wsm check failed: same-cycle property");

// consequent must hold in the cycle after the antecedent
`define WSM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wsm check failed: next-cycle property");

`endif

// File: sv/wsm_pkg.sv
// shared constants, codes and controller/datapath command types
// no dependencies
`timescale 1ns / 1ps

package wsm_pkg;

   // parameter defaults
   localparam int SAMPLES_DEF    = 1024;
   localparam int MAX_SMOOTH_DEF = 255;

   // algorithm constants
   localparam int PASSES       = 3;
   localparam int PEAK_FLOOR   = 3;
   localparam int BOX_STEPS    = 16;
   localparam int PROD_W       = 31;
   localparam int RECIP3       = 683;
   localparam int RECIP3_SHIFT = 11;
   localparam int SAT_POS      = 32767;
   localparam int SAT_NEG_MAG  = 32768;

   // field widths
   localparam int VAL_W = 16;
   localparam int POS_W = 11;
   localparam int OP_W  = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
   localparam logic [OP_W-1:0] OP_RUN  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ = 2'd2;

   // status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic accept;
      logic copy_rd;
      logic copy_wr;
      logic pass_init;
      logic pass_next;
      logic pt_rd;
      logic pt_acc;
      logic div_start;
      logic div_long;
      logic pt_wr;
      logic res_init;
      logic res_rd;
      logic res_mul;
      logic res_wr;
      logic idx_inc;
      logic read_done;
      logic run_done;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic idx_last;
      logic idx_neg;
      logic pass_last;
      logic smooth_zero;
      logic peaks_ok;
      logic div_done;
   } stat_type;

endpackage

// File: sv/waveform_box_smoother_core.sv
// top level of the waveform box smoother: controller plus datapath
// depends on wsm_pkg, wsm_ctrl, wsm_dpath, wsm_div
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | operation, position, sample_in
//   rsp     | out       | rsp_valid/rsp_ready | value_out, position_echo, status
//   csr     | in        | csr_valid/csr_ready | smoothness (always ready)
//
// load and bad operations: result registered at the accept edge, next request
// may follow in the next cycle; read: through the registered memory port, then the result register
// run: a copy of the mirrored samples, then 3 passes of the box average
// (a window sum and one division a point by the 16-step divider), then when peaks
// allow a rescale of every point (one division a point, 31-step divider)
// reset is synchronous; memories are not cleared, a read before a run is undefined
// a stalled result holds the result register and blocks new requests
`timescale 1ns / 1ps

module waveform_box_smoother_core #(
   parameter int SAMPLES    = wsm_pkg::SAMPLES_DEF,
   parameter int MAX_SMOOTH = wsm_pkg::MAX_SMOOTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [7:0]                        csr_smoothness,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [wsm_pkg::OP_W-1:0]          req_operation,
   input  logic [wsm_pkg::POS_W-1:0]         req_position,
   input  logic signed [wsm_pkg::VAL_W-1:0]  req_sample_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [wsm_pkg::VAL_W-1:0]  rsp_value_out,
   output logic [wsm_pkg::POS_W-1:0]         rsp_position_echo,
   output logic                              rsp_status
);

   wsm_pkg::cmd_type  cmd;
   wsm_pkg::stat_type stat;

   // configuration writes are taken in any cycle
   assign csr_ready = 1'b1;

   wsm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   wsm_dpath #(
      .SAMPLES    (SAMPLES),
      .MAX_SMOOTH (MAX_SMOOTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_smoothness    (csr_smoothness),
      .req_operation     (req_operation),
      .req_position      (req_position),
      .req_sample_in     (req_sample_in),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_value_out     (rsp_value_out),
      .rsp_position_echo (rsp_position_echo),
      .rsp_status        (rsp_status)
   );

endmodule

// File: sv/wsm_div.sv
// shared restoring divider, one quotient bit per cycle, signed dividend
// depends on wsm_pkg
`timescale 1ns / 1ps

module wsm_div #(
   parameter int DW = wsm_pkg::PROD_W
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           long_mode,
   input  logic signed [DW:0]             dividend,
   input  logic [wsm_pkg::VAL_W-1:0]      divisor,
   output logic                           done,
   output logic [DW-1:0]                  quotient,
   output logic                           negative
);

   localparam int CNTW = $clog2(DW + 1);
   localparam int RW   = wsm_pkg::VAL_W;

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   dvd_ff, dvd_in;
   logic            neg_ff, neg_in;
   logic [RW-1:0]   div_ff, div_in;

   logic [DW:0]     mag_full;
   logic [DW-1:0]   mag;
   logic [RW:0]     trial;
   logic            ge;

   // magnitude of the dividend and one restoring step
   always_comb begin
      mag_full = dividend[DW] ? (-dividend) : dividend;
      mag      = mag_full[DW-1:0];
      trial    = {rem_ff, dvd_ff[DW-1]};
      ge       = trial >= {1'b0, div_ff};
   end

   // next state
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      neg_in  = neg_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[DW];
         div_in  = divisor;
         if (long_mode) begin
            cnt_in = CNTW'(DW);
            rem_in = '0;
            dvd_in = mag;
         end else begin
            cnt_in = CNTW'(wsm_pkg::BOX_STEPS);
            rem_in = RW'(mag >> wsm_pkg::BOX_STEPS);
            dvd_in = mag << (DW - wsm_pkg::BOX_STEPS);
         end
      end else if (busy_ff) begin
         rem_in = ge ? RW'(trial - {1'b0, div_ff}) : trial[RW-1:0];
         dvd_in = {dvd_ff[DW-2:0], ge};
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      neg_ff <= neg_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;
   assign negative = neg_ff;

endmodule

// File: sv/wsm_dpath.sv
// datapath: sample, ping-pong work memories, window sum, peaks, rescale
// depends on wsm_pkg and wsm_div
`timescale 1ns / 1ps

module wsm_dpath #(
   parameter int SAMPLES    = wsm_pkg::SAMPLES_DEF,
   parameter int MAX_SMOOTH = wsm_pkg::MAX_SMOOTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [7:0]                        csr_smoothness,
   input  logic [wsm_pkg::OP_W-1:0]          req_operation,
   input  logic [wsm_pkg::POS_W-1:0]         req_position,
   input  logic signed [wsm_pkg::VAL_W-1:0]  req_sample_in,
   input  wsm_pkg::cmd_type                  cmd,
   output wsm_pkg::stat_type                 stat,
   output logic signed [wsm_pkg::VAL_W-1:0]  rsp_value_out,
   output logic [wsm_pkg::POS_W-1:0]         rsp_position_echo,
   output logic                              rsp_status
);

   localparam int N    = 2 * SAMPLES;
   localparam int AW   = $clog2(N);
   localparam int BW   = $clog2(SAMPLES);
   localparam int RMAX = (MAX_SMOOTH + 2) / 3;
   localparam int RW   = $clog2(RMAX + 1);
   localparam int CW   = $clog2(2 * RMAX + 2);
   localparam int VW   = wsm_pkg::VAL_W;
   localparam int SUMW = VW + CW + 1;
   localparam int DW   = (SUMW > wsm_pkg::PROD_W) ? SUMW : wsm_pkg::PROD_W;
   localparam int DW1  = DW + 1;
   localparam int IW   = $clog2(N + 2 * RMAX + 2) + 1;
   localparam int PW   = $clog2(wsm_pkg::PASSES);
   localparam logic FINAL_B = (wsm_pkg::PASSES % 2) == 1;

   localparam logic signed [IW-1:0] ONE_I  = 1;
   localparam logic signed [IW-1:0] N_I    = IW'(N);
   localparam logic signed [IW-1:0] LAST_I = IW'(N - 1);
   localparam logic signed [IW-1:0] S_I    = IW'(SAMPLES);
   localparam logic [10:0]          MAX11  = 11'(MAX_SMOOTH);
   localparam logic [VW-1:0]        FLOOR  = VW'(wsm_pkg::PEAK_FLOOR);

   // stores
   logic signed [VW-1:0] base_mem [0:SAMPLES-1];
   logic signed [VW-1:0] mem_a [0:N-1];
   logic signed [VW-1:0] mem_b [0:N-1];
   logic signed [VW-1:0] base_rd_ff;
   logic signed [VW-1:0] a0_ff, a1_ff, b0_ff, b1_ff;

   // registers
   logic [7:0]              smooth_ff;
   logic [RW-1:0]           radius_ff;
   logic signed [IW-1:0]    idx_ff;
   logic [PW-1:0]           pass_ff;
   logic signed [SUMW-1:0]  sum_ff;
   logic [CW-1:0]           cnt_ff;
   logic [VW-1:0]           orig_peak_ff;
   logic [VW-1:0]           new_peak_ff;
   logic signed [DW:0]      prod_ff;
   logic [wsm_pkg::POS_W-1:0] pos_ff;
   logic                    rd_ok_ff;
   logic                    sel_ff;
   logic signed [VW-1:0]    value_ff;
   logic [wsm_pkg::POS_W-1:0] echo_ff;
   logic                    status_ff;

   // combinational signals
   logic [10:0]             s11, s_cl, s_plus;
   logic [21:0]             recip_prod;
   logic signed [IW-1:0]    r_ext, drop_i, add_i, mir_i, pos_i;
   logic                    drop_ok, add_ok, load_ok, rd_ok;
   logic [AW-1:0]           addr0, addr1;
   logic [BW-1:0]           base_addr;
   logic                    src_b;
   logic signed [VW-1:0]    drop_val, add_val, fin_val, wr_val;
   logic [VW-1:0]           box_val, res_val;
   logic                    a_we, b_we, base_we;
   logic signed [32:0]      mul_w;
   logic signed [DW:0]      div_dvd;
   logic [VW-1:0]           div_dsr;
   logic                    div_done, div_neg;
   logic [DW-1:0]           div_q;

   function automatic logic [VW-1:0] abs_val(input logic signed [VW-1:0] v);
      abs_val = v[VW-1] ? (VW'(0) - v) : v;
   endfunction

   // radius = ceil(clamped smoothness / 3) via reciprocal multiply
   always_comb begin
      s11        = {3'b000, smooth_ff};
      s_cl       = (s11 > MAX11) ? MAX11 : s11;
      s_plus     = s_cl + 11'd2;
      recip_prod = 22'(s_plus) * 22'(wsm_pkg::RECIP3);
   end

   // window and index arithmetic
   always_comb begin
      r_ext     = $signed({{(IW - RW){1'b0}}, radius_ff});
      drop_i    = idx_ff - r_ext - ONE_I;
      add_i     = idx_ff + r_ext;
      drop_ok   = !drop_i[IW-1];
      add_ok    = add_i < N_I;
      mir_i     = LAST_I - idx_ff;
      base_addr = (idx_ff < S_I) ? idx_ff[BW-1:0] : mir_i[BW-1:0];
      pos_i     = IW'(req_position);
      load_ok   = {3'b000, req_position} < 14'(SAMPLES);
      rd_ok     = {3'b000, req_position} < 14'(N);
      addr0     = cmd.accept ? pos_i[AW-1:0] : (cmd.pt_rd ? drop_i[AW-1:0] : idx_ff[AW-1:0]);
      addr1     = add_i[AW-1:0];
      src_b     = pass_ff[0];
      drop_val  = src_b ? b0_ff : a0_ff;
      add_val   = src_b ? b1_ff : a1_ff;
      fin_val   = FINAL_B ? b0_ff : a0_ff;
   end

   // divider operands, quotient sign and saturation
   always_comb begin
      div_dvd = cmd.div_long ? prod_ff : DW1'(sum_ff);
      div_dsr = cmd.div_long ? new_peak_ff : VW'(cnt_ff);
      box_val = div_neg ? (VW'(0) - div_q[VW-1:0]) : div_q[VW-1:0];
      if (!div_neg && (div_q > DW'(wsm_pkg::SAT_POS))) begin
         res_val = VW'(wsm_pkg::SAT_POS);
      end else if (div_neg && (div_q > DW'(wsm_pkg::SAT_NEG_MAG))) begin
         res_val = {1'b1, {(VW - 1){1'b0}}};
      end else begin
         res_val = box_val;
      end
      mul_w = fin_val * $signed({1'b0, orig_peak_ff});
   end

   // write enables and write data
   always_comb begin
      base_we = cmd.accept && (req_operation == wsm_pkg::OP_LOAD) && load_ok;
      a_we    = cmd.copy_wr || (cmd.pt_wr && src_b) || (cmd.res_wr && !FINAL_B);
      b_we    = (cmd.pt_wr && !src_b) || (cmd.res_wr && FINAL_B);
      if (cmd.copy_wr) begin
         wr_val = base_rd_ff;
      end else if (cmd.pt_wr) begin
         wr_val = box_val;
      end else begin
         wr_val = res_val;
      end
   end

   // sample store
   always_ff @(posedge clock) begin
      if (base_we) begin
         base_mem[pos_i[BW-1:0]] <= req_sample_in;
      end
      base_rd_ff <= base_mem[base_addr];
   end

   // work memory a
   always_ff @(posedge clock) begin
      if (a_we) begin
         mem_a[idx_ff[AW-1:0]] <= wr_val;
      end
      a0_ff <= mem_a[addr0];
      a1_ff <= mem_a[addr1];
   end

   // work memory b
   always_ff @(posedge clock) begin
      if (b_we) begin
         mem_b[idx_ff[AW-1:0]] <= wr_val;
      end
      b0_ff <= mem_b[addr0];
      b1_ff <= mem_b[addr1];
   end

   // configuration and derived radius
   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= '0;
         radius_ff <= '0;
      end else begin
         if (csr_valid) begin
            smooth_ff <= csr_smoothness;
         end
         radius_ff <= recip_prod[wsm_pkg::RECIP3_SHIFT +: RW];
      end
   end

   // run sequencing state: index, pass, window, peaks
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         pass_ff      <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         orig_peak_ff <= '0;
         new_peak_ff  <= '0;
         sel_ff       <= 1'b0;
      end else begin
         if (cmd.accept && (req_operation == wsm_pkg::OP_RUN)) begin
            idx_ff       <= '0;
            pass_ff      <= '0;
            orig_peak_ff <= '0;
            new_peak_ff  <= '0;
         end else if (cmd.pass_init) begin
            idx_ff <= -r_ext;
            sum_ff <= '0;
            cnt_ff <= '0;
         end else if (cmd.res_init) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + ONE_I;
         end
         if (cmd.pass_next) begin
            pass_ff <= pass_ff + PW'(1);
         end
         if (cmd.pt_acc) begin
            sum_ff <= sum_ff - (drop_ok ? SUMW'(drop_val) : SUMW'(0))
                             + (add_ok ? SUMW'(add_val) : SUMW'(0));
            cnt_ff <= cnt_ff + CW'(add_ok) - CW'(drop_ok);
         end
         if (cmd.copy_wr && (abs_val(base_rd_ff) > orig_peak_ff)) begin
            orig_peak_ff <= abs_val(base_rd_ff);
         end
         if (cmd.pt_wr && stat.pass_last && (abs_val(box_val) > new_peak_ff)) begin
            new_peak_ff <= abs_val(box_val);
         end
         if (cmd.run_done) begin
            sel_ff <= stat.smooth_zero ? 1'b0 : FINAL_B;
         end
      end
   end

   // product register and request fields kept for later results
   always_ff @(posedge clock) begin
      if (cmd.res_mul) begin
         prod_ff <= DW1'(mul_w);
      end
      if (cmd.accept) begin
         pos_ff   <= req_position;
         rd_ok_ff <= rd_ok;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.accept && (req_operation != wsm_pkg::OP_RUN)
            && (req_operation != wsm_pkg::OP_READ)) begin
         value_ff  <= '0;
         echo_ff   <= req_position;
         status_ff <= ((req_operation == wsm_pkg::OP_LOAD) && load_ok)
                      ? wsm_pkg::STATUS_OK : wsm_pkg::STATUS_ERR;
      end else if (cmd.read_done) begin
         value_ff  <= rd_ok_ff ? (sel_ff ? b0_ff : a0_ff) : VW'(0);
         echo_ff   <= pos_ff;
         status_ff <= rd_ok_ff ? wsm_pkg::STATUS_OK : wsm_pkg::STATUS_ERR;
      end else if (cmd.run_done) begin
         value_ff  <= '0;
         echo_ff   <= pos_ff;
         status_ff <= wsm_pkg::STATUS_OK;
      end
   end

   wsm_div #(
      .DW(DW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .long_mode (cmd.div_long),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .done      (div_done),
      .quotient  (div_q),
      .negative  (div_neg)
   );

   // status to the controller
   always_comb begin
      stat.idx_last    = idx_ff == LAST_I;
      stat.idx_neg     = idx_ff[IW-1];
      stat.pass_last   = pass_ff == PW'(wsm_pkg::PASSES - 1);
      stat.smooth_zero = smooth_ff == 8'd0;
      stat.peaks_ok    = (new_peak_ff > FLOOR) && (orig_peak_ff > FLOOR);
      stat.div_done    = div_done;
   end

   assign rsp_value_out     = value_ff;
   assign rsp_position_echo = echo_ff;
   assign rsp_status        = status_ff;

endmodule

// File: sv/wsm_ctrl.sv
// controller: request decode, run sequencer and result handshake
// depends on wsm_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "waveform_box_smoother_core_defines.svh"

module wsm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [wsm_pkg::OP_W-1:0]  req_operation,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  wsm_pkg::stat_type         stat,
   output wsm_pkg::cmd_type          cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_READ     = 4'd1;
   localparam logic [3:0] S_COPY_RD  = 4'd2;
   localparam logic [3:0] S_COPY_WR  = 4'd3;
   localparam logic [3:0] S_PT_RD    = 4'd4;
   localparam logic [3:0] S_PT_ACC   = 4'd5;
   localparam logic [3:0] S_PT_DIV   = 4'd6;
   localparam logic [3:0] S_PT_WAIT  = 4'd7;
   localparam logic [3:0] S_PT_WR    = 4'd8;
   localparam logic [3:0] S_RES_CHK  = 4'd9;
   localparam logic [3:0] S_RES_RD   = 4'd10;
   localparam logic [3:0] S_RES_MUL  = 4'd11;
   localparam logic [3:0] S_RES_DIV  = 4'd12;
   localparam logic [3:0] S_RES_WAIT = 4'd13;
   localparam logic [3:0] S_RES_WR   = 4'd14;
   localparam logic [3:0] S_DONE     = 4'd15;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       result_set;

   // a request is taken only when the result slot is free or freeing
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.accept = 1'b1;
               if (req_operation == wsm_pkg::OP_RUN) begin
                  state_in = S_COPY_RD;
               end else if (req_operation == wsm_pkg::OP_READ) begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.read_done = 1'b1;
            state_in      = S_IDLE;
         end
         S_COPY_RD: begin
            cmd.copy_rd = 1'b1;
            state_in    = S_COPY_WR;
         end
         S_COPY_WR: begin
            cmd.copy_wr = 1'b1;
            if (!stat.idx_last) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_COPY_RD;
            end else if (stat.smooth_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.pass_init = 1'b1;
               state_in      = S_PT_RD;
            end
         end
         S_PT_RD: begin
            cmd.pt_rd = 1'b1;
            state_in  = S_PT_ACC;
         end
         S_PT_ACC: begin
            cmd.pt_acc = 1'b1;
            if (stat.idx_neg) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_PT_RD;
            end else begin
               state_in = S_PT_DIV;
            end
         end
         S_PT_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_PT_WAIT;
         end
         S_PT_WAIT: begin
            if (stat.div_done) begin
               state_in = S_PT_WR;
            end
         end
         S_PT_WR: begin
            cmd.pt_wr = 1'b1;
            if (!stat.idx_last) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_PT_RD;
            end else if (stat.pass_last) begin
               state_in = S_RES_CHK;
            end else begin
               cmd.pass_init = 1'b1;
               cmd.pass_next = 1'b1;
               state_in      = S_PT_RD;
            end
         end
         S_RES_CHK: begin
            if (stat.peaks_ok) begin
               cmd.res_init = 1'b1;
               state_in     = S_RES_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RES_RD: begin
            cmd.res_rd = 1'b1;
            state_in   = S_RES_MUL;
         end
         S_RES_MUL: begin
            cmd.res_mul = 1'b1;
            state_in    = S_RES_DIV;
         end
         S_RES_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_long  = 1'b1;
            state_in      = S_RES_WAIT;
         end
         S_RES_WAIT: begin
            cmd.div_long = 1'b1;
            if (stat.div_done) begin
               state_in = S_RES_WR;
            end
         end
         S_RES_WR: begin
            cmd.res_wr = 1'b1;
            if (stat.idx_last) begin
               state_in = S_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_RES_RD;
            end
         end
         S_DONE: begin
            cmd.run_done = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result slot: a new result wins over the take of the old one
   always_comb begin
      result_set = (cmd.accept && (req_operation != wsm_pkg::OP_RUN)
                    && (req_operation != wsm_pkg::OP_READ))
                   || cmd.read_done || cmd.run_done;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (result_set) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // checks
   `WSM_ASSERT_NOW(div_done_in_wait, stat.div_done, (state_ff == S_PT_WAIT) || (state_ff == S_RES_WAIT))
   `WSM_ASSERT_NOW(no_result_overrun, result_set, !(rsp_valid_ff && !rsp_ready))
   `WSM_ASSERT_NEXT(run_starts_copy, cmd.accept && (req_operation == wsm_pkg::OP_RUN), state_ff == S_COPY_RD)

endmodule

// File: tb/waveform_box_smoother_core_checker.sv
// checker for the waveform box smoother core: watches the csr, req and rsp channels,
// predicts each response from its own smoothing model and compares; depends on wsm_pkg
`timescale 1ns / 1ps

module waveform_box_smoother_core_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [7:0]                       csr_smoothness,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [wsm_pkg::OP_W-1:0]         req_operation,
   input  logic [wsm_pkg::POS_W-1:0]        req_position,
   input  logic signed [wsm_pkg::VAL_W-1:0] req_sample_in,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic signed [wsm_pkg::VAL_W-1:0] rsp_value_out,
   input  logic [wsm_pkg::POS_W-1:0]        rsp_position_echo,
   input  logic                             rsp_status,
   output int                               fail_count,
   output int                               pending
);

   localparam int NSAMP = wsm_pkg::SAMPLES_DEF;
   localparam int NPTS  = 2 * wsm_pkg::SAMPLES_DEF;
   localparam int VW    = wsm_pkg::VAL_W;

   typedef struct {
      logic signed [wsm_pkg::VAL_W-1:0] value;
      logic [wsm_pkg::POS_W-1:0]        position;
      logic                             status;
   } point_result_type;

   logic signed [VW-1:0] loaded_samples [NSAMP];
   logic signed [VW-1:0] smoothed_buf [NPTS];
   logic signed [VW-1:0] pass_buf [NPTS];
   logic [7:0]           smooth_level;
   point_result_type     expected_results [$];

   // largest magnitude in the smoothed buffer
   function automatic int buffer_peak();
      int peak;
      int mag;
      peak = 0;
      for (int i = 0; i < NPTS; i++) begin
         mag = (smoothed_buf[i] < 0) ? -int'(smoothed_buf[i]) : int'(smoothed_buf[i]);
         if (mag > peak) peak = mag;
      end
      return peak;
   endfunction

   // one centred box average with clipped edges
   task automatic box_average(input int radius);
      int wsum;
      int wcnt;
      wsum = 0;
      wcnt = 0;
      for (int j = 0; j <= radius && j < NPTS; j++) begin
         wsum += smoothed_buf[j];
         wcnt++;
      end
      pass_buf[0] = VW'(wsum / wcnt);
      for (int i = 1; i < NPTS; i++) begin
         if (i - radius - 1 >= 0) begin
            wsum -= smoothed_buf[i - radius - 1];
            wcnt--;
         end
         if (i + radius < NPTS) begin
            wsum += smoothed_buf[i + radius];
            wcnt++;
         end
         pass_buf[i] = VW'(wsum / wcnt);
      end
      smoothed_buf = pass_buf;
   endtask

   // mirror, then for nonzero smoothness smooth three times and, when both peaks clear the floor, restore the peak
   task automatic smooth_waveform();
      int level;
      int old_peak;
      int new_peak;
      longint scaled;
      for (int i = 0; i < NSAMP; i++) begin
         smoothed_buf[i] = loaded_samples[i];
         smoothed_buf[NSAMP + i] = loaded_samples[NSAMP - 1 - i];
      end
      level = smooth_level;
      if (level == 0) return;
      if (level > wsm_pkg::MAX_SMOOTH_DEF) level = wsm_pkg::MAX_SMOOTH_DEF;
      old_peak = buffer_peak();
      for (int p = 0; p < wsm_pkg::PASSES; p++)
         box_average((level + wsm_pkg::PASSES - 1) / wsm_pkg::PASSES);
      new_peak = buffer_peak();
      if (new_peak > wsm_pkg::PEAK_FLOOR && old_peak > wsm_pkg::PEAK_FLOOR) begin
         for (int i = 0; i < NPTS; i++) begin
            scaled = longint'(smoothed_buf[i]) * longint'(old_peak);
            scaled = scaled / longint'(new_peak);
            if (scaled > wsm_pkg::SAT_POS) scaled = wsm_pkg::SAT_POS;
            if (scaled < -wsm_pkg::SAT_NEG_MAG) scaled = -wsm_pkg::SAT_NEG_MAG;
            smoothed_buf[i] = VW'(scaled);
         end
      end
   endtask

   // predict on each request, compare on each response
   always @(posedge clock) begin
      point_result_type exp_res;
      point_result_type got;
      if (reset) begin
         smooth_level = 0;
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) smooth_level = csr_smoothness;
         if (req_valid && req_ready) begin
            exp_res.value = '0;
            exp_res.position = req_position;
            exp_res.status = wsm_pkg::STATUS_OK;
            if (req_operation == wsm_pkg::OP_LOAD) begin
               if (req_position < NSAMP) loaded_samples[req_position] = req_sample_in;
               else exp_res.status = wsm_pkg::STATUS_ERR;
            end else if (req_operation == wsm_pkg::OP_RUN) begin
               smooth_waveform();
            end else if (req_operation == wsm_pkg::OP_READ) begin
               exp_res.value = smoothed_buf[req_position];
            end else begin
               exp_res.status = wsm_pkg::STATUS_ERR;
            end
            expected_results.push_back(exp_res);
         end
         if (rsp_valid && rsp_ready) begin
            got.value = rsp_value_out;
            got.position = rsp_position_echo;
            got.status = rsp_status;
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("response with no request pending: value %0d pos %0d status %0d",
                           got.value, got.position, got.status);
            end else begin
               exp_res = expected_results.pop_front();
               if (got.value !== exp_res.value || got.position !== exp_res.position ||
                   got.status !== exp_res.status) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected value %0d pos %0d status %0d, got %0d %0d %0d",
                              exp_res.value, exp_res.position, exp_res.status,
                              got.value, got.position, got.status);
               end
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

// File: tb/waveform_box_smoother_core_tb.sv
// testbench top for the waveform box smoother core: clock, reset, request and csr
// stimulus, response stalls and the verdict; depends on wsm_pkg, the core and the checker
`timescale 1ns / 1ps

module waveform_box_smoother_core_tb;

   localparam int PW = wsm_pkg::POS_W;
   localparam int VW = wsm_pkg::VAL_W;
   localparam logic [wsm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 1000000;

   logic                       clock = 0;
   logic                       reset = 1;
   logic                       csr_valid = 0;
   logic                       csr_ready;
   logic [7:0]                 csr_smoothness = 0;
   logic                       req_valid = 0;
   logic                       req_ready;
   logic [wsm_pkg::OP_W-1:0]   req_operation = wsm_pkg::OP_LOAD;
   logic [PW-1:0]              req_position = 0;
   logic signed [VW-1:0]       req_sample_in = 0;
   logic                       rsp_valid;
   logic                       rsp_ready = 0;
   logic signed [VW-1:0]       rsp_value_out;
   logic [PW-1:0]              rsp_position_echo;
   logic                       rsp_status;
   int                         fail_count;
   int                         pending;
   int                         idle_cycles = 0;
   int                         hold_asked = 0;
   int                         hold_done = 0;
   int                         stall_left = 0;
   bit                         quiet = 0;
   bit                         smoothed = 0;

   always #5 clock = ~clock;

   waveform_box_smoother_core u_top (.*);

   waveform_box_smoother_core_checker u_checker (.*);

   // idle length: mostly short, a few long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(0, 2);
      if (r < 95) return $urandom_range(3, 10);
      return $urandom_range(20, 60);
   endfunction

   // response side stalls, plus the long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 0;
         stall_left <= stall_left - 1;
      end else if (hold_done != hold_asked) begin
         hold_done <= hold_asked;
         stall_left <= 400;
         rsp_ready <= 0;
      end else if (quiet || $urandom_range(0, 99) < 70) begin
         rsp_ready <= 1;
      end else begin
         stall_left <= gap_len();
         rsp_ready <= 0;
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("waveform_box_smoother_core verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // offer one request and wait for it to be taken
   task automatic send_request(input logic [wsm_pkg::OP_W-1:0] op, input int pos,
                               input int sample);
      int gap;
      gap = (quiet || $urandom_range(0, 1)) ? 0 : gap_len();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_operation <= op;
      req_position <= PW'(pos);
      req_sample_in <= VW'(sample);
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      if (op == wsm_pkg::OP_RUN) smoothed = 1;
   endtask

   // random mix of loads, reads and unused codes
   task automatic random_requests(input int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 45 || !smoothed)
            send_request(wsm_pkg::OP_LOAD, ($urandom_range(0, 9) == 0)
                         ? $urandom_range(1024, 2047) : $urandom_range(0, 1023),
                         $urandom_range(0, 65535));
         else if (r < 95)
            send_request(wsm_pkg::OP_READ, $urandom_range(0, 2047), $urandom_range(0, 65535));
         else
            send_request(OP_UNUSED, $urandom_range(0, 2047), $urandom_range(0, 65535));
      end
   endtask

   // wait for every response, then write smoothness
   task automatic set_smoothness(input int level);
      req_valid <= 0;
      do @(negedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
      csr_valid <= 1;
      csr_smoothness <= 8'(level);
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 0;
   endtask

   initial begin
      int v;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // fill every sample with a tiny waveform, no idling
      quiet = 1;
      for (int i = 0; i < wsm_pkg::SAMPLES_DEF; i++)
         send_request(wsm_pkg::OP_LOAD, i, $urandom_range(0, 6) - 3);
      quiet = 0;
      send_request(wsm_pkg::OP_LOAD, 1024, 16'h5555);
      send_request(wsm_pkg::OP_LOAD, 2047, 16'haaaa);
      send_request(OP_UNUSED, 2047, 0);
      send_request(OP_UNUSED, 0, 16'hffff);
      // zero smoothness only mirrors
      send_request(wsm_pkg::OP_RUN, 2047, 0);
      send_request(wsm_pkg::OP_READ, 0, 0);
      send_request(wsm_pkg::OP_READ, 1023, 0);
      send_request(wsm_pkg::OP_READ, 1024, 0);
      send_request(wsm_pkg::OP_READ, 2047, 0);

      // tiny waveform so neither peak clears the floor
      set_smoothness($urandom_range(2, 254));
      send_request(wsm_pkg::OP_RUN, 0, 0);
      random_requests(60);

      // extremes at the front of the waveform
      for (int i = 0; i < 4; i++) begin
         case (i)
            0: v = -32768;
            1: v = 32767;
            2: v = 0;
            default: v = -1;
         endcase
         send_request(wsm_pkg::OP_LOAD, i, v);
      end
      random_requests(150);

      // long receiver hold-off while requests keep coming
      hold_asked <= hold_asked + 1;
      random_requests(40);

      set_smoothness(1);
      random_requests(150);
      send_request(wsm_pkg::OP_RUN, 0, 0);
      random_requests(150);

      set_smoothness(255);
      random_requests(160);
      send_request(wsm_pkg::OP_RUN, $urandom_range(0, 2047), 0);
      random_requests(100);

      req_valid <= 0;
      do @(negedge clock); while (pending != 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("waveform_box_smoother_core verification clean");
      else
         $display("waveform_box_smoother_core verification failed");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/wsm_pkg.sv
sv/wsm_div.sv
sv/wsm_dpath.sv
sv/wsm_ctrl.sv
sv/waveform_box_smoother_core.sv
tb/waveform_box_smoother_core_checker.sv
tb/waveform_box_smoother_core_tb.sv
